// File: sv/tcpu_pkg.sv
// tcpu_pkg: shared widths, sizes, opcodes, instruction classes and the command/status
// structs between the decode/execute controller and its datapath.
// No dependencies.
`default_nettype none

package tcpu_pkg;

    localparam int DATA_W    = 16;
    localparam int PL_ADDR_W = 11;
    localparam int MEM_WORDS = 2048;
    localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam bit MEM_POW2  = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);
    localparam int NUM_REGS  = 8;
    localparam int REG_AW    = $clog2(NUM_REGS);

    // Register-format opcodes, bits 14..9
    localparam logic [5:0] OP_ADD     = 6'd0;
    localparam logic [5:0] OP_SUB     = 6'd1;
    localparam logic [5:0] OP_MUL     = 6'd2;
    localparam logic [5:0] OP_DIV     = 6'd3;
    localparam logic [5:0] OP_EQ      = 6'd4;
    localparam logic [5:0] OP_NE      = 6'd5;
    localparam logic [5:0] OP_LOAD    = 6'd15;
    localparam logic [5:0] OP_STORE   = 6'd16;
    localparam logic [5:0] OP_SYSCALL = 6'd63;

    // Immediate-format opcodes, bits 14..13
    localparam logic [1:0] IOP_JUMP  = 2'd0;
    localparam logic [1:0] IOP_JCOND = 2'd1;
    localparam logic [1:0] IOP_SPARE = 2'd2;
    localparam logic [1:0] IOP_MOVE  = 2'd3;

    // Instruction class, resolved once when a request is taken in.
    typedef enum logic [3:0] {
        CLS_IGNORE,
        CLS_PRELOAD,
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_DIV,
        CLS_EQ,
        CLS_NE,
        CLS_LOAD,
        CLS_STORE,
        CLS_SYSCALL,
        CLS_JUMP,
        CLS_JCOND,
        CLS_MOVE,
        CLS_BAD
    } cls_t;

    // Register file read address source
    typedef enum logic [1:0] {
        RSEL_OP1,
        RSEL_OP2,
        RSEL_R0,
        RSEL_IMM
    } rsel_t;

    // Result value source
    typedef enum logic [1:0] {
        VSEL_ALU,
        VSEL_DIV,
        VSEL_MEM
    } vsel_t;

    typedef struct packed {
        logic  cap_in;
        logic  clr_we;
        logic  rf_rd;
        rsel_t rf_rsel;
        logic  lat_a;
        logic  lat_b;
        logic  div_start;
        logic  addr_load;
        logic  mem_we;
        logic  mem_rd;
        logic  val_load;
        vsel_t val_sel;
        logic  rf_we;
        logic  halt_chk;
        logic  out_load;
    } dp_cmd_t;

    typedef struct packed {
        cls_t cls;
        logic clr_last;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/toy_cpu16_decode_execute.sv
// Sequenced by tcpu_ctrl: dropped and bad requests go straight to the result; divides, and
// load, store and preload when MEM_WORDS is not a power of two, go through the 16-step
// shared divider. One request in flight: the next is taken the cycle after the result
// loads, and m_ready can hold off the result and so the next request.
// Reset: a clearing pass zeroes all 2048 memory words, s_ready low; regs and halt
// clear at once.
`default_nettype none

module toy_cpu16_decode_execute (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_kind,
    input  wire logic [tcpu_pkg::DATA_W-1:0]    s_instr_word,
    input  wire logic [tcpu_pkg::DATA_W-1:0]    s_current_pc,
    input  wire logic [tcpu_pkg::DATA_W-1:0]    s_predicted_pc,
    input  wire logic [tcpu_pkg::PL_ADDR_W-1:0] s_preload_addr,
    input  wire logic [tcpu_pkg::DATA_W-1:0]    s_preload_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_halted,
    output logic                                m_bad_opcode,
    output logic                                m_is_jump,
    output logic                                m_mispredicted,
    output logic      [tcpu_pkg::DATA_W-1:0]    m_redirect_pc,
    output logic                                m_reg_written,
    output logic      [tcpu_pkg::REG_AW-1:0]    m_dest_index,
    output logic      [tcpu_pkg::DATA_W-1:0]    m_dest_value
);
    import tcpu_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tcpu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tcpu_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_kind         (s_kind),
        .s_instr_word   (s_instr_word),
        .s_current_pc   (s_current_pc),
        .s_predicted_pc (s_predicted_pc),
        .s_preload_addr (s_preload_addr),
        .s_preload_data (s_preload_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_halted       (m_halted),
        .m_bad_opcode   (m_bad_opcode),
        .m_is_jump      (m_is_jump),
        .m_mispredicted (m_mispredicted),
        .m_redirect_pc  (m_redirect_pc),
        .m_reg_written  (m_reg_written),
        .m_dest_index   (m_dest_index),
        .m_dest_value   (m_dest_value)
    );

`ifndef SYNTHESIS
    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded while output register busy");

    // only one request in flight
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap_in |=> !s_ready)
        else $error("request accepted while another is in flight");

    // a freshly started divide is never reported done in the next cycle
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> !stat.div_done)
        else $error("divider done flag not cleared on start");

    // a bad opcode has no other effect
    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_opcode) |-> (!m_reg_written && !m_is_jump && !m_mispredicted))
        else $error("bad opcode result carries side effects");
`endif

endmodule

`default_nettype wire

// File: sv/tcpu_ram.sv
// tcpu_ram: generic single-clock RAM, one write port and one registered
// read port. No dependencies.
`default_nettype none

module tcpu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                       aclk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/tcpu_div.sv
// tcpu_div: iterative restoring unsigned divider, one quotient bit per cycle.
// Depends on tcpu_pkg. A zero divisor yields an all-ones quotient.
`default_nettype none

module tcpu_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [tcpu_pkg::DATA_W-1:0]  dividend,
    input  wire logic [tcpu_pkg::DATA_W-1:0]  divisor,
    output logic      [tcpu_pkg::DATA_W-1:0]  quot,
    output logic      [tcpu_pkg::DATA_W-1:0]  rem,
    output logic                              done
);
    import tcpu_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DATA_W-2:0], ge};
            rem_reg <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        end
    end

    assign quot = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: sv/tcpu_datapath.sv
// tcpu_datapath: request capture, register file, word memory, ALU, shared
// divider and result register. Depends on tcpu_pkg, tcpu_ram, tcpu_div.
`default_nettype none

module tcpu_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire tcpu_pkg::dp_cmd_t              cmd,
    output tcpu_pkg::dp_stat_t                  stat,
    input  wire logic                           s_kind,
    input  wire logic [tcpu_pkg::DATA_W-1:0]    s_instr_word,
    input  wire logic [tcpu_pkg::DATA_W-1:0]    s_current_pc,
    input  wire logic [tcpu_pkg::DATA_W-1:0]    s_predicted_pc,
    input  wire logic [tcpu_pkg::PL_ADDR_W-1:0] s_preload_addr,
    input  wire logic [tcpu_pkg::DATA_W-1:0]    s_preload_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_halted,
    output logic                                m_bad_opcode,
    output logic                                m_is_jump,
    output logic                                m_mispredicted,
    output logic      [tcpu_pkg::DATA_W-1:0]    m_redirect_pc,
    output logic                                m_reg_written,
    output logic      [tcpu_pkg::REG_AW-1:0]    m_dest_index,
    output logic      [tcpu_pkg::DATA_W-1:0]    m_dest_value
);
    import tcpu_pkg::*;

    localparam int IMM_W = 10;
    localparam logic [DATA_W-1:0] MEM_DIVISOR = DATA_W'(MEM_WORDS);

    function automatic cls_t decode(input logic kind, input logic [DATA_W-1:0] w);
        cls_t c;
        c = CLS_BAD;
        if (kind) begin
            c = CLS_PRELOAD;
        end else if (!w[15]) begin
            unique case (w[14:9])
                OP_ADD:     c = CLS_ADD;
                OP_SUB:     c = CLS_SUB;
                OP_MUL:     c = CLS_MUL;
                OP_DIV:     c = CLS_DIV;
                OP_EQ:      c = CLS_EQ;
                OP_NE:      c = CLS_NE;
                OP_LOAD:    c = CLS_LOAD;
                OP_STORE:   c = CLS_STORE;
                OP_SYSCALL: c = CLS_SYSCALL;
                default:    c = CLS_BAD;
            endcase
        end else begin
            unique case (w[14:13])
                IOP_JUMP:  c = CLS_JUMP;
                IOP_JCOND: c = CLS_JCOND;
                IOP_MOVE:  c = CLS_MOVE;
                default:   c = CLS_BAD;
            endcase
        end
        return c;
    endfunction

    // Captured request
    cls_t                 cls_reg;
    logic [DATA_W-1:0]    word_reg;
    logic [DATA_W-1:0]    cur_pc_reg;
    logic [DATA_W-1:0]    pred_pc_reg;
    logic [PL_ADDR_W-1:0] pl_addr_reg;
    logic [DATA_W-1:0]    pl_data_reg;

    // Working state
    logic                 halt_reg;
    logic [DATA_W-1:0]    a_reg;
    logic [DATA_W-1:0]    b_reg;
    logic [DATA_W-1:0]    val_reg;
    logic [MEM_AW-1:0]    addr_reg;
    logic [MEM_AW-1:0]    clr_addr_reg;
    logic [NUM_REGS-1:0]  rf_valid_reg;
    logic                 rf_rvalid_reg;

    // Result register
    logic                 m_valid_reg;
    logic                 m_halted_reg;
    logic                 m_bad_reg;
    logic                 m_jump_reg;
    logic                 m_mis_reg;
    logic [DATA_W-1:0]    m_redir_reg;
    logic                 m_wr_reg;
    logic [REG_AW-1:0]    m_didx_reg;
    logic [DATA_W-1:0]    m_dval_reg;

    logic [REG_AW-1:0]    dst_idx;
    logic [REG_AW-1:0]    op1_idx;
    logic [REG_AW-1:0]    op2_idx;
    logic [REG_AW-1:0]    imm_idx;
    logic [IMM_W-1:0]     imm;
    logic [DATA_W-1:0]    imm_ext;

    logic [REG_AW-1:0]    rf_raddr;
    logic [REG_AW-1:0]    rf_waddr;
    logic [DATA_W-1:0]    rf_rdata;
    logic [DATA_W-1:0]    rf_val;

    logic [DATA_W-1:0]    addr_src;
    logic [DATA_W-1:0]    div_dividend;
    logic [DATA_W-1:0]    div_divisor;
    logic [DATA_W-1:0]    div_quot;
    logic [DATA_W-1:0]    div_rem;
    logic                 div_done;
    logic [MEM_AW-1:0]    addr_next;

    logic                 mem_we;
    logic [MEM_AW-1:0]    mem_waddr;
    logic [DATA_W-1:0]    mem_wdata;
    logic [DATA_W-1:0]    mem_rdata;

    logic [DATA_W-1:0]    mul_lo;
    logic [DATA_W-1:0]    alu_val;
    logic [DATA_W-1:0]    val_next;

    logic                 writes;
    logic                 jump;
    logic                 mis;

    assign dst_idx = word_reg[8:6];
    assign op1_idx = word_reg[5:3];
    assign op2_idx = word_reg[2:0];
    assign imm_idx = word_reg[12:10];
    assign imm     = word_reg[IMM_W-1:0];
    assign imm_ext = {{(DATA_W-IMM_W){1'b0}}, imm};

    // ---------------- request capture ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cls_reg <= CLS_IGNORE;
        end else if (cmd.cap_in) begin
            // once halted, every request is dropped
            cls_reg <= halt_reg ? CLS_IGNORE : decode(s_kind, s_instr_word);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            word_reg    <= s_instr_word;
            cur_pc_reg  <= s_current_pc;
            pred_pc_reg <= s_predicted_pc;
            pl_addr_reg <= s_preload_addr;
            pl_data_reg <= s_preload_data;
        end
    end

    // ---------------- register file ----------------
    always_comb begin
        unique case (cmd.rf_rsel)
            RSEL_OP1: rf_raddr = op1_idx;
            RSEL_OP2: rf_raddr = op2_idx;
            RSEL_R0:  rf_raddr = '0;
            RSEL_IMM: rf_raddr = imm_idx;
            default:  rf_raddr = op1_idx;
        endcase
    end

    assign rf_waddr = (cls_reg == CLS_MOVE) ? imm_idx : dst_idx;

    tcpu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_rf (
        .aclk  (aclk),
        .we    (cmd.rf_we),
        .waddr (rf_waddr),
        .wdata (val_reg),
        .re    (cmd.rf_rd),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    // never-written registers read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg  <= '0;
            rf_rvalid_reg <= 1'b0;
        end else begin
            if (cmd.rf_we) begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            if (cmd.rf_rd) begin
                rf_rvalid_reg <= rf_valid_reg[rf_raddr];
            end
        end
    end

    assign rf_val = rf_rvalid_reg ? rf_rdata : '0;

    always_ff @(posedge aclk) begin
        if (cmd.lat_a) begin
            a_reg <= rf_val;
        end
        if (cmd.lat_b) begin
            b_reg <= rf_val;
        end
    end

    // ---------------- divider: quotient or address reduction ----------------
    assign addr_src     = (cls_reg == CLS_PRELOAD) ?
                          {{(DATA_W-PL_ADDR_W){1'b0}}, pl_addr_reg} : a_reg;
    assign div_dividend = (cls_reg == CLS_DIV) ? a_reg : addr_src;
    assign div_divisor  = (cls_reg == CLS_DIV) ? b_reg : MEM_DIVISOR;

    tcpu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    assign addr_next = MEM_POW2 ? addr_src[MEM_AW-1:0] : div_rem[MEM_AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.addr_load) begin
            addr_reg <= addr_next;
        end
    end

    // ---------------- word memory ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_we) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign mem_we    = cmd.clr_we | cmd.mem_we;
    assign mem_waddr = cmd.clr_we ? clr_addr_reg : addr_reg;
    assign mem_wdata = cmd.clr_we ? '0 :
                       (cls_reg == CLS_PRELOAD) ? pl_data_reg : b_reg;

    tcpu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.mem_rd),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    // ---------------- ALU ----------------
    assign mul_lo = a_reg * b_reg;

    always_comb begin
        unique case (cls_reg)
            CLS_ADD:   alu_val = a_reg + b_reg;
            CLS_SUB:   alu_val = a_reg - b_reg;
            CLS_MUL:   alu_val = mul_lo;
            CLS_EQ:    alu_val = {{(DATA_W-1){1'b0}}, a_reg == b_reg};
            CLS_NE:    alu_val = {{(DATA_W-1){1'b0}}, a_reg != b_reg};
            CLS_MOVE:  alu_val = imm_ext;
            CLS_JUMP:  alu_val = imm_ext;
            // taken when the tested register holds one, else fall through
            CLS_JCOND: alu_val = (a_reg == DATA_W'(1)) ? imm_ext : cur_pc_reg + 1'b1;
            default:   alu_val = '0;
        endcase
    end

    always_comb begin
        unique case (cmd.val_sel)
            VSEL_ALU: val_next = alu_val;
            VSEL_DIV: val_next = div_quot;
            VSEL_MEM: val_next = mem_rdata;
            default:  val_next = alu_val;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.val_load) begin
            val_reg <= val_next;
        end
    end

    // syscall: a_reg holds r0 at this point
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_reg <= 1'b0;
        end else if (cmd.halt_chk && (a_reg == '0)) begin
            halt_reg <= 1'b1;
        end
    end

    // ---------------- result register ----------------
    assign writes = (cls_reg == CLS_ADD) || (cls_reg == CLS_SUB) || (cls_reg == CLS_MUL) ||
                    (cls_reg == CLS_DIV) || (cls_reg == CLS_EQ) || (cls_reg == CLS_NE) ||
                    (cls_reg == CLS_LOAD) || (cls_reg == CLS_MOVE);
    assign jump   = (cls_reg == CLS_JUMP) || (cls_reg == CLS_JCOND);
    assign mis    = jump && (val_reg != pred_pc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_halted_reg <= halt_reg;
            m_bad_reg    <= (cls_reg == CLS_BAD);
            m_jump_reg   <= jump;
            m_mis_reg    <= mis;
            m_redir_reg  <= mis ? val_reg : '0;
            m_wr_reg     <= writes;
            m_didx_reg   <= writes ? rf_waddr : '0;
            m_dval_reg   <= writes ? val_reg : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_halted       = m_halted_reg;
    assign m_bad_opcode   = m_bad_reg;
    assign m_is_jump      = m_jump_reg;
    assign m_mispredicted = m_mis_reg;
    assign m_redirect_pc  = m_redir_reg;
    assign m_reg_written  = m_wr_reg;
    assign m_dest_index   = m_didx_reg;
    assign m_dest_value   = m_dval_reg;

    // ---------------- status ----------------
    assign stat.cls      = cls_reg;
    assign stat.clr_last = (clr_addr_reg == MEM_AW'(MEM_WORDS - 1));
    assign stat.div_done = div_done;
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

// File: sv/tcpu_ctrl.sv
// tcpu_ctrl: sequencer for the decode/execute block. Steps the datapath
// through reads, execute, divide, memory and write-back. Depends on tcpu_pkg.
`default_nettype none

module tcpu_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tcpu_pkg::dp_stat_t stat,
    output tcpu_pkg::dp_cmd_t       cmd
);
    import tcpu_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RD_A,
        ST_RD_B,
        ST_LAT_B,
        ST_DIV_GO,
        ST_ADDR,
        ST_DIV_WAIT,
        ST_MEM,
        ST_MEM_WAIT,
        ST_EXEC,
        ST_WB,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.cap_in = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (stat.cls)
                    CLS_IGNORE, CLS_BAD: state_next = ST_DONE;
                    CLS_PRELOAD:         state_next = ST_ADDR;
                    CLS_JUMP, CLS_MOVE:  state_next = ST_EXEC;
                    default:             state_next = ST_RD_A;
                endcase
            end
            ST_RD_A: begin
                cmd.rf_rd = 1'b1;
                if (stat.cls == CLS_SYSCALL) begin
                    cmd.rf_rsel = RSEL_R0;
                end else if (stat.cls == CLS_JCOND) begin
                    cmd.rf_rsel = RSEL_IMM;
                end else begin
                    cmd.rf_rsel = RSEL_OP1;
                end
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                cmd.lat_a   = 1'b1;
                cmd.rf_rd   = 1'b1;
                cmd.rf_rsel = RSEL_OP2;
                state_next  = ST_LAT_B;
            end
            ST_LAT_B: begin
                cmd.lat_b = 1'b1;
                if (stat.cls == CLS_DIV) begin
                    state_next = ST_DIV_GO;
                end else if (stat.cls == CLS_LOAD || stat.cls == CLS_STORE) begin
                    state_next = ST_ADDR;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_ADDR: begin
                if (MEM_POW2) begin
                    cmd.addr_load = 1'b1;
                    state_next    = ST_MEM;
                end else begin
                    // reduce the address through the divider remainder
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    if (stat.cls == CLS_DIV) begin
                        cmd.val_load = 1'b1;
                        cmd.val_sel  = VSEL_DIV;
                        state_next   = ST_WB;
                    end else begin
                        cmd.addr_load = 1'b1;
                        state_next    = ST_MEM;
                    end
                end
            end
            ST_MEM: begin
                if (stat.cls == CLS_LOAD) begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_MEM_WAIT;
                end else begin
                    cmd.mem_we = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_MEM_WAIT: begin
                cmd.val_load = 1'b1;
                cmd.val_sel  = VSEL_MEM;
                state_next   = ST_WB;
            end
            ST_EXEC: begin
                cmd.val_load = 1'b1;
                cmd.val_sel  = VSEL_ALU;
                cmd.halt_chk = (stat.cls == CLS_SYSCALL);
                if (stat.cls == CLS_SYSCALL || stat.cls == CLS_JUMP ||
                    stat.cls == CLS_JCOND) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                cmd.rf_we  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking bench for toy_cpu16_decode_execute: directed and random instruction
// and preload requests, every result checked against a cycle-free model of the machine.
// Depends on tcpu_pkg and the toy_cpu16_decode_execute RTL.
`timescale 1ns / 100ps

module testbench;

    import tcpu_pkg::*;

    localparam int RANDOM_REQS    = 1280;
    localparam int IDLE_PCT       = 15;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTS     = 40;

    typedef struct {
        logic                 kind;
        logic [DATA_W-1:0]    iw;
        logic [DATA_W-1:0]    cur;
        logic [DATA_W-1:0]    pred;
        logic [PL_ADDR_W-1:0] pa;
        logic [DATA_W-1:0]    pd;
        bit                   drain;
    } cpu_request_t;

    typedef struct packed {
        logic              halted;
        logic              bad;
        logic              jump;
        logic              mis;
        logic [DATA_W-1:0] redirect;
        logic              reg_wr;
        logic [REG_AW-1:0] dest;
        logic [DATA_W-1:0] value;
    } exec_outcome_t;

    logic                 aclk;
    logic                 aresetn        = 1'b0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic                 s_kind         = 1'b0;
    logic [DATA_W-1:0]    s_instr_word   = '0;
    logic [DATA_W-1:0]    s_current_pc   = '0;
    logic [DATA_W-1:0]    s_predicted_pc = '0;
    logic [PL_ADDR_W-1:0] s_preload_addr = '0;
    logic [DATA_W-1:0]    s_preload_data = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic                 m_halted;
    logic                 m_bad_opcode;
    logic                 m_is_jump;
    logic                 m_mispredicted;
    logic [DATA_W-1:0]    m_redirect_pc;
    logic                 m_reg_written;
    logic [REG_AW-1:0]    m_dest_index;
    logic [DATA_W-1:0]    m_dest_value;

    // Machine state as the model sees it
    logic [DATA_W-1:0] cpu_regs [0:NUM_REGS-1];
    logic [DATA_W-1:0] cpu_mem  [0:MEM_WORDS-1];
    logic              cpu_halted;

    cpu_request_t  pending_reqs [$];
    exec_outcome_t expected_outcomes [$];

    bit req_taken  = 1'b0;
    bit drain_next = 1'b0;
    int n_errors    = 0;
    int n_reqs      = 0;
    int n_checked   = 0;
    int n_preloads  = 0;
    int n_jumps     = 0;
    int n_redirects = 0;
    int n_bad       = 0;
    int n_writes    = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    wire calm = (n_reqs >= 600) && (n_reqs < 900);

    toy_cpu16_decode_execute DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_instr_word   (s_instr_word),
        .s_current_pc   (s_current_pc),
        .s_predicted_pc (s_predicted_pc),
        .s_preload_addr (s_preload_addr),
        .s_preload_data (s_preload_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_halted       (m_halted),
        .m_bad_opcode   (m_bad_opcode),
        .m_is_jump      (m_is_jump),
        .m_mispredicted (m_mispredicted),
        .m_redirect_pc  (m_redirect_pc),
        .m_reg_written  (m_reg_written),
        .m_dest_index   (m_dest_index),
        .m_dest_value   (m_dest_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Executes one request against the model state and returns what the block must report.
    function automatic exec_outcome_t execute_request(input logic kind, input logic [15:0] iw,
            input logic [15:0] cur, input logic [15:0] pred, input logic [10:0] pa,
            input logic [15:0] pd);
        exec_outcome_t r;
        logic [15:0]   a;
        logic [15:0]   b;
        logic [15:0]   imm;
        logic [15:0]   nxt;
        logic [2:0]    ri;
        r = '0;
        if (!cpu_halted) begin
            if (kind) begin
                cpu_mem[pa % MEM_WORDS] = pd;
            end else if (!iw[15]) begin
                a = cpu_regs[iw[5:3]];
                b = cpu_regs[iw[2:0]];
                r.reg_wr = 1'b1;
                r.dest   = iw[8:6];
                case (iw[14:9])
                    OP_ADD: r.value = a + b;
                    OP_SUB: r.value = a - b;
                    OP_MUL: r.value = a * b;
                    OP_DIV: r.value = (b == 16'd0) ? 16'hFFFF : a / b;
                    OP_EQ:  r.value = {15'd0, a == b};
                    OP_NE:  r.value = {15'd0, a != b};
                    OP_LOAD: r.value = cpu_mem[a % MEM_WORDS];
                    OP_STORE: begin
                        cpu_mem[a % MEM_WORDS] = b;
                        r.reg_wr = 1'b0;
                    end
                    OP_SYSCALL: begin
                        if (cpu_regs[0] == 16'd0) cpu_halted = 1'b1;
                        r.reg_wr = 1'b0;
                    end
                    default: begin
                        r.bad    = 1'b1;
                        r.reg_wr = 1'b0;
                    end
                endcase
                if (r.reg_wr) begin
                    cpu_regs[r.dest] = r.value;
                end else begin
                    r.dest  = '0;
                    r.value = '0;
                end
            end else begin
                ri  = iw[12:10];
                imm = {6'd0, iw[9:0]};
                case (iw[14:13])
                    IOP_JUMP, IOP_JCOND: begin
                        r.jump = 1'b1;
                        if (iw[14:13] == IOP_JUMP || cpu_regs[ri] == 16'd1) nxt = imm;
                        else nxt = cur + 16'd1;
                        if (nxt != pred) begin
                            r.mis      = 1'b1;
                            r.redirect = nxt;
                        end
                    end
                    IOP_MOVE: begin
                        cpu_regs[ri] = imm;
                        r.reg_wr     = 1'b1;
                        r.dest       = ri;
                        r.value      = imm;
                    end
                    default: r.bad = 1'b1;
                endcase
            end
        end
        r.halted = cpu_halted;
        return r;
    endfunction

    function automatic logic [15:0] reg_instr(input logic [5:0] opc, input logic [2:0] d,
            input logic [2:0] a, input logic [2:0] b);
        return {1'b0, opc, d, a, b};
    endfunction

    function automatic logic [15:0] imm_instr(input logic [1:0] opc, input logic [2:0] r,
            input logic [9:0] imm);
        return {1'b1, opc, r, imm};
    endfunction

    function automatic logic [9:0] rand_imm();
        case ($urandom_range(4))
            0: return 10'd0;
            1: return 10'd1;
            2: return 10'($urandom_range(15));
            3: return 10'h3FF;
            default: return 10'($urandom);
        endcase
    endfunction

    // Random words must never clear r0, or a later syscall would halt the machine early.
    function automatic logic [15:0] keep_r0_live(input logic [15:0] iw);
        logic [15:0] w;
        w = iw;
        if (!w[15] && w[8:6] == 3'd0) w[6] = 1'b1;
        if (w[15] && w[12:10] == 3'd0 && w[9:0] == 10'd0) w[0] = 1'b1;
        return w;
    endfunction

    task automatic queue_exec(input logic [15:0] iw, input logic [15:0] cur,
            input logic [15:0] pred);
        cpu_request_t rq;
        rq.kind  = 1'b0;
        rq.iw    = iw;
        rq.cur   = cur;
        rq.pred  = pred;
        rq.pa    = 11'($urandom);
        rq.pd    = 16'($urandom);
        rq.drain = drain_next;
        drain_next = 1'b0;
        pending_reqs.push_back(rq);
    endtask

    task automatic queue_preload(input logic [10:0] pa, input logic [15:0] pd);
        cpu_request_t rq;
        rq.kind  = 1'b1;
        rq.iw    = 16'($urandom);
        rq.cur   = 16'($urandom);
        rq.pred  = 16'($urandom);
        rq.pa    = pa;
        rq.pd    = pd;
        rq.drain = drain_next;
        drain_next = 1'b0;
        pending_reqs.push_back(rq);
    endtask

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS) $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
            input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %h, expected %h",
                                      n_checked, name, got, want));
    endtask

    // Driver: presents the next request at the falling edge once the previous one was taken
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || req_taken)) begin
            if (pending_reqs.size() != 0
                    && !(pending_reqs[0].drain && expected_outcomes.size() != 0)
                    && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                s_valid        <= 1'b1;
                s_kind         <= pending_reqs[0].kind;
                s_instr_word   <= pending_reqs[0].iw;
                s_current_pc   <= pending_reqs[0].cur;
                s_predicted_pc <= pending_reqs[0].pred;
                s_preload_addr <= pending_reqs[0].pa;
                s_preload_data <= pending_reqs[0].pd;
                void'(pending_reqs.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side ready, with one long hold-off to back the block up
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && n_reqs >= 300) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: checks results and predicts accepted requests
    always @(posedge aclk) begin
        exec_outcome_t want;
        if (!aresetn) begin
            req_taken = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                              n_checked));
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("halted", 16'(m_halted), 16'(want.halted));
                    check_field("bad_opcode", 16'(m_bad_opcode), 16'(want.bad));
                    check_field("is_jump", 16'(m_is_jump), 16'(want.jump));
                    check_field("mispredicted", 16'(m_mispredicted), 16'(want.mis));
                    check_field("redirect_pc", m_redirect_pc, want.redirect);
                    check_field("reg_written", 16'(m_reg_written), 16'(want.reg_wr));
                    check_field("dest_index", 16'(m_dest_index), 16'(want.dest));
                    check_field("dest_value", m_dest_value, want.value);
                end
                n_checked++;
            end
            req_taken = s_valid && s_ready;
            if (req_taken) begin
                want = execute_request(s_kind, s_instr_word, s_current_pc, s_predicted_pc,
                                       s_preload_addr, s_preload_data);
                expected_outcomes.push_back(want);
                n_reqs++;
                if (s_kind && !want.halted) n_preloads++;
                if (want.jump) n_jumps++;
                if (want.mis) n_redirects++;
                if (want.bad) n_bad++;
                if (want.reg_wr) n_writes++;
            end
        end
    end

    // Watchdog: reset clearing pass and the long hold-off both fit well inside the limit
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int          i;
        int          sel;
        logic [15:0] cur;
        logic [15:0] pred;
        logic [9:0]  imm;
        logic [1:0]  iop;
        logic [5:0]  opc;

        for (i = 0; i < NUM_REGS; i++) cpu_regs[i] = '0;
        for (i = 0; i < MEM_WORDS; i++) cpu_mem[i] = '0;
        cpu_halted = 1'b0;

        // Directed: field extremes, each opcode, wrap and corner cases
        queue_preload(11'd0, 16'hFFFF);
        queue_preload(11'h7FF, 16'h8001);
        queue_exec(imm_instr(IOP_MOVE, 3'd0, 10'h3FF), 16'($urandom), 16'($urandom));
        queue_exec(imm_instr(IOP_MOVE, 3'd1, 10'd0), 16'($urandom), 16'($urandom));
        queue_exec(imm_instr(IOP_MOVE, 3'd2, 10'd1), 16'($urandom), 16'($urandom));
        queue_exec(imm_instr(IOP_MOVE, 3'd7, 10'd5), 16'($urandom), 16'($urandom));
        queue_exec(reg_instr(OP_ADD, 3'd3, 3'd0, 3'd7), 16'($urandom), 16'($urandom));
        queue_exec(reg_instr(OP_SUB, 3'd4, 3'd1, 3'd0), 16'($urandom), 16'($urandom));
        queue_exec(reg_instr(OP_MUL, 3'd5, 3'd4, 3'd4), 16'($urandom), 16'($urandom));
        queue_exec(reg_instr(OP_DIV, 3'd6, 3'd0, 3'd7), 16'($urandom), 16'($urandom));
        // divide by zero
        queue_exec(reg_instr(OP_DIV, 3'd6, 3'd0, 3'd1), 16'($urandom), 16'($urandom));
        queue_exec(reg_instr(OP_EQ, 3'd3, 3'd2, 3'd2), 16'($urandom), 16'($urandom));
        queue_exec(reg_instr(OP_NE, 3'd3, 3'd0, 3'd0), 16'($urandom), 16'($urandom));
        queue_exec(reg_instr(OP_LOAD, 3'd5, 3'd1, 3'd0), 16'($urandom), 16'($urandom));
        // addresses above the memory depth wrap
        queue_exec(reg_instr(OP_STORE, 3'd0, 3'd4, 3'd0), 16'($urandom), 16'($urandom));
        queue_exec(reg_instr(OP_LOAD, 3'd3, 3'd6, 3'd0), 16'($urandom), 16'($urandom));
        queue_exec(reg_instr(OP_LOAD, 3'd5, 3'd4, 3'd0), 16'($urandom), 16'($urandom));
        queue_exec(reg_instr(6'd6, 3'd1, 3'd2, 3'd3), 16'($urandom), 16'($urandom));
        queue_exec(reg_instr(6'd62, 3'd1, 3'd2, 3'd3), 16'($urandom), 16'($urandom));
        queue_exec(imm_instr(IOP_SPARE, 3'd2, 10'h2AA), 16'($urandom), 16'($urandom));
        queue_exec(imm_instr(IOP_JUMP, 3'd5, 10'h3FF), 16'h0010, 16'h03FF);
        queue_exec(imm_instr(IOP_JUMP, 3'd0, 10'd0), 16'h0020, 16'h0021);
        queue_exec(imm_instr(IOP_JCOND, 3'd2, 10'h155), 16'h0040, 16'h0041);
        queue_exec(imm_instr(IOP_JCOND, 3'd1, 10'd5), 16'hFFFF, 16'h0000);
        queue_exec(imm_instr(IOP_JCOND, 3'd1, 10'd5), 16'h0100, 16'h0005);
        // syscall with r0 nonzero must not halt
        queue_exec(reg_instr(OP_SYSCALL, 3'd0, 3'd0, 3'd0), 16'($urandom), 16'($urandom));

        // Random: mostly well-formed instructions, some undefined opcodes and raw noise
        for (i = 0; i < RANDOM_REQS; i++) begin
            if (i % 400 == 399) drain_next = 1'b1;
            sel = $urandom_range(99);
            cur = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
            if (sel < 10) begin
                queue_preload(($urandom_range(3) == 0) ? 11'($urandom_range(31)) : 11'($urandom),
                              16'($urandom));
            end else if (sel < 25) begin
                queue_exec(keep_r0_live(imm_instr(IOP_MOVE, 3'($urandom), rand_imm())),
                           cur, 16'($urandom));
            end else if (sel < 55) begin
                opc = 6'($urandom_range(OP_NE));
                queue_exec(reg_instr(opc, 3'($urandom_range(1, 7)), 3'($urandom),
                                     3'($urandom)), cur, 16'($urandom));
            end else if (sel < 60) begin
                queue_exec(reg_instr(OP_LOAD, 3'($urandom_range(1, 7)), 3'($urandom),
                                     3'($urandom)), cur, 16'($urandom));
            end else if (sel < 65) begin
                queue_exec(reg_instr(OP_STORE, 3'($urandom), 3'($urandom), 3'($urandom)),
                           cur, 16'($urandom));
            end else if (sel < 80) begin
                iop = $urandom_range(1) ? IOP_JCOND : IOP_JUMP;
                imm = rand_imm();
                case ($urandom_range(2))
                    0: pred = {6'd0, imm};
                    1: pred = cur + 16'd1;
                    default: pred = 16'($urandom);
                endcase
                queue_exec(imm_instr(iop, 3'($urandom), imm), cur, pred);
            end else if (sel < 84) begin
                queue_exec(reg_instr(OP_SYSCALL, 3'($urandom), 3'($urandom), 3'($urandom)),
                           cur, 16'($urandom));
            end else if (sel < 90) begin
                if ($urandom_range(1)) begin
                    opc = 6'($urandom_range(6, 60));
                    if (opc >= OP_LOAD) opc = opc + 6'd2;
                    queue_exec(reg_instr(opc, 3'($urandom), 3'($urandom), 3'($urandom)),
                               cur, 16'($urandom));
                end else begin
                    queue_exec(imm_instr(IOP_SPARE, 3'($urandom), 10'($urandom)),
                               cur, 16'($urandom));
                end
            end else begin
                queue_exec(keep_r0_live(16'($urandom)), cur, 16'($urandom));
            end
        end

        // Halt: clear r0 once the block is idle, syscall, then requests that must be ignored
        drain_next = 1'b1;
        queue_exec(imm_instr(IOP_MOVE, 3'd0, 10'd0), 16'($urandom), 16'($urandom));
        queue_exec(reg_instr(OP_SYSCALL, 3'd0, 3'd0, 3'd0), 16'($urandom), 16'($urandom));
        queue_preload(11'd7, 16'h1234);
        queue_exec(reg_instr(OP_ADD, 3'd3, 3'd2, 3'd2), 16'($urandom), 16'($urandom));
        queue_exec(imm_instr(IOP_MOVE, 3'd4, 10'h3FF), 16'($urandom), 16'($urandom));
        queue_exec(imm_instr(IOP_JUMP, 3'd0, 10'd9), 16'h0000, 16'h0001);
        queue_exec(reg_instr(OP_SYSCALL, 3'd0, 3'd0, 3'd0), 16'($urandom), 16'($urandom));

        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid || expected_outcomes.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d requests: %0d preloads, %0d jumps (%0d redirected), %0d undefined",
                 n_reqs, n_preloads, n_jumps, n_redirects, n_bad);
        $display("opcodes, %0d register writes; %0d results compared, %0d mismatches, halted %0b.",
                 n_writes, n_checked, n_errors, cpu_halted);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/tcpu_pkg.sv
sv/tcpu_ram.sv
sv/tcpu_div.sv
sv/tcpu_datapath.sv
sv/tcpu_ctrl.sv
sv/toy_cpu16_decode_execute.sv
test/testbench.sv
